// ===== hw/rtl/dda_pkg.sv =====
package dda_pkg;

  // Field widths of the block.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // Derived widths of the fixed-point state.
  localparam int POS_BITS   = COORD_BITS + 1 + FRAC_BITS;
  localparam int STEP_BITS  = FRAC_BITS + 2;
  localparam int CNT_BITS   = COORD_BITS + 1;
  localparam int REM_BITS   = CNT_BITS + 1;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int DCNT_BITS  = $clog2(QUO_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic signed [STEP_BITS-1:0]  step_t;
  typedef logic signed [CNT_BITS-1:0]   diff_t;
  typedef logic        [CNT_BITS-1:0]   cnt_t;
  typedef logic        [REM_BITS-1:0]   rem_t;
  typedef logic        [QUO_BITS-1:0]   quo_t;
  typedef logic        [DCNT_BITS-1:0]  dcnt_t;

  // Item function codes.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_BOTTOM = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_TOP    = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Integer part of a fixed-point position, truncated toward zero.
  function automatic coord_t pixel_coord(pos_t p);
    logic [CNT_BITS-1:0] whole;
    logic                bump;
    whole = p[POS_BITS-1:FRAC_BITS];
    bump  = p[POS_BITS-1] && (p[FRAC_BITS-1:0] != '0);
    return coord_t'(whole + CNT_BITS'(bump));
  endfunction

  // Coordinate moved into the fixed-point position format.
  function automatic pos_t scale(coord_t c);
    return pos_t'({c[COORD_BITS-1], c, {FRAC_BITS{1'b0}}});
  endfunction

  // Inclusive range test of an exact position against two bounds.
  function automatic logic in_range(pos_t p, coord_t lo, coord_t hi);
    return (scale(lo) <= p) && (p <= scale(hi));
  endfunction

endpackage

// ===== hw/rtl/dda_line_with_pixel_clip.sv =====
// DDA line rasterizer with a per-pixel clip test. A load item (func = 0) takes two
// endpoints, sets the line length to max(|dx|,|dy|) and returns the start pixel;
// each advance item (func = 1) moves one step along the line and returns the next
// pixel, with last set on the final one. A line has length+1 pixels. An advance
// with no line in progress returns a result with active = 0. Pixel coordinates are
// the fixed-point position truncated toward zero; visible compares the exact
// position with the clip box, bounds inclusive. A load runs the per-axis
// increments through one shared restoring divider, one quotient bit per cycle,
// for x and then for y; the next item is taken only once the start pixel is in
// the output register. A zero-length load skips the divider. The output register
// lets an item be taken while the previous result is still being transferred.
// The clip registers are written through the configuration port; the user must
// do so only while the block is idle, which the block itself does not enforce.
module dda_line_with_pixel_clip (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  dda_pkg::coord_t          start_x,
  input  dda_pkg::coord_t          start_y,
  input  dda_pkg::coord_t          end_x,
  input  dda_pkg::coord_t          end_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output dda_pkg::coord_t          pixel_x,
  output dda_pkg::coord_t          pixel_y,
  output logic                     visible,
  output logic                     last,
  output logic                     active,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  dda_pkg::coord_t          cfg_data
);

  dda_pkg::state_t state, state_next;

  dda_pkg::coord_t clip_left, clip_bottom, clip_right, clip_top;

  dda_pkg::pos_t  pos_x, pos_x_next, pos_y, pos_y_next;
  dda_pkg::step_t step_x, step_x_next, step_y, step_y_next;
  dda_pkg::cnt_t  steps_left, steps_left_next;
  logic           line_active, line_active_next;

  // Divider registers.
  dda_pkg::cnt_t  len, len_next;
  dda_pkg::cnt_t  mag_y, mag_y_next;
  logic           neg_x, neg_x_next, neg_y, neg_y_next;
  dda_pkg::rem_t  rem, rem_next;
  dda_pkg::quo_t  quo, quo_next;
  dda_pkg::dcnt_t dcnt, dcnt_next;
  logic           axis, axis_next;

  // Output register.
  logic            out_valid_next;
  dda_pkg::coord_t pixel_x_next, pixel_y_next;
  logic            visible_next, last_next, active_next;

  logic in_accept;
  logic out_free;

  // Load arithmetic.
  dda_pkg::diff_t dx, dy;
  dda_pkg::cnt_t  abs_dx, abs_dy;

  // Divider step.
  logic           div_ge;
  dda_pkg::rem_t  div_sub;
  dda_pkg::quo_t  div_quo;
  dda_pkg::step_t div_step;

  // Advance arithmetic.
  dda_pkg::pos_t  adv_x, adv_y;
  dda_pkg::cnt_t  adv_left;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != dda_pkg::ST_IDLE) ||
                     ((func == dda_pkg::FUNC_ADVANCE) && !out_free);
  assign in_accept = in_valid && !in_stall;

  // Endpoint differences and their magnitudes.
  always_comb begin
    dx     = dda_pkg::diff_t'(end_x) - dda_pkg::diff_t'(start_x);
    dy     = dda_pkg::diff_t'(end_y) - dda_pkg::diff_t'(start_y);
    abs_dx = dda_pkg::cnt_t'(dx[dda_pkg::CNT_BITS-1] ? -dx : dx);
    abs_dy = dda_pkg::cnt_t'(dy[dda_pkg::CNT_BITS-1] ? -dy : dy);
  end

  // One restoring-division step: one quotient bit per cycle.
  always_comb begin
    div_ge  = rem >= dda_pkg::rem_t'(len);
    div_sub = div_ge ? rem - dda_pkg::rem_t'(len) : rem;
    div_quo = {quo[dda_pkg::QUO_BITS-2:0], div_ge};
    if ((axis ? neg_y : neg_x)) begin
      div_step = -dda_pkg::step_t'({1'b0, div_quo});
    end else begin
      div_step = dda_pkg::step_t'({1'b0, div_quo});
    end
  end

  // Position after one step along the line.
  always_comb begin
    adv_x    = pos_x + dda_pkg::pos_t'(step_x);
    adv_y    = pos_y + dda_pkg::pos_t'(step_y);
    adv_left = steps_left - dda_pkg::cnt_t'(1);
  end

  // Sequencer: next state, line state and output register.
  always_comb begin
    state_next       = state;
    pos_x_next       = pos_x;
    pos_y_next       = pos_y;
    step_x_next      = step_x;
    step_y_next      = step_y;
    steps_left_next  = steps_left;
    line_active_next = line_active;
    len_next         = len;
    mag_y_next       = mag_y;
    neg_x_next       = neg_x;
    neg_y_next       = neg_y;
    rem_next         = rem;
    quo_next         = quo;
    dcnt_next        = dcnt;
    axis_next        = axis;
    out_valid_next   = out_valid && out_stall;
    pixel_x_next     = pixel_x;
    pixel_y_next     = pixel_y;
    visible_next     = visible;
    last_next        = last;
    active_next      = active;

    unique case (state)
      dda_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (func == dda_pkg::FUNC_LOAD) begin
            // Start a new line and set up the x-axis division.
            len_next         = (abs_dy > abs_dx) ? abs_dy : abs_dx;
            mag_y_next       = abs_dy;
            neg_x_next       = dx[dda_pkg::CNT_BITS-1];
            neg_y_next       = dy[dda_pkg::CNT_BITS-1];
            pos_x_next       = dda_pkg::scale(start_x);
            pos_y_next       = dda_pkg::scale(start_y);
            steps_left_next  = len_next;
            line_active_next = len_next != '0;
            rem_next         = dda_pkg::rem_t'(abs_dx);
            quo_next         = '0;
            dcnt_next        = dda_pkg::dcnt_t'(dda_pkg::QUO_BITS - 1);
            axis_next        = 1'b0;
            if (len_next == '0) begin
              step_x_next = '0;
              step_y_next = '0;
              state_next  = dda_pkg::ST_EMIT;
            end else begin
              state_next  = dda_pkg::ST_DIV;
            end
          end else if (!line_active || steps_left == '0) begin
            // Advance with no line in progress.
            line_active_next = 1'b0;
            out_valid_next   = 1'b1;
            pixel_x_next     = '0;
            pixel_y_next     = '0;
            visible_next     = 1'b0;
            last_next        = 1'b0;
            active_next      = 1'b0;
          end else begin
            // Advance one step and return the new pixel.
            pos_x_next       = adv_x;
            pos_y_next       = adv_y;
            steps_left_next  = adv_left;
            line_active_next = adv_left != '0;
            out_valid_next   = 1'b1;
            pixel_x_next     = dda_pkg::pixel_coord(adv_x);
            pixel_y_next     = dda_pkg::pixel_coord(adv_y);
            visible_next     = dda_pkg::in_range(adv_x, clip_left, clip_right) &&
                               dda_pkg::in_range(adv_y, clip_bottom, clip_top);
            last_next        = adv_left == '0;
            active_next      = 1'b1;
          end
        end
      end

      dda_pkg::ST_DIV: begin
        quo_next  = div_quo;
        rem_next  = dda_pkg::rem_t'({div_sub[dda_pkg::REM_BITS-2:0], 1'b0});
        dcnt_next = dcnt - dda_pkg::dcnt_t'(1);
        if (dcnt == '0) begin
          if (!axis) begin
            // The x increment is done; start the y division.
            step_x_next = div_step;
            rem_next    = dda_pkg::rem_t'(mag_y);
            quo_next    = '0;
            dcnt_next   = dda_pkg::dcnt_t'(dda_pkg::QUO_BITS - 1);
            axis_next   = 1'b1;
          end else begin
            step_y_next = div_step;
            state_next  = dda_pkg::ST_EMIT;
          end
        end
      end

      dda_pkg::ST_EMIT: begin
        // Return the start pixel once the output register is free.
        if (out_free) begin
          out_valid_next = 1'b1;
          pixel_x_next   = dda_pkg::pixel_coord(pos_x);
          pixel_y_next   = dda_pkg::pixel_coord(pos_y);
          visible_next   = dda_pkg::in_range(pos_x, clip_left, clip_right) &&
                           dda_pkg::in_range(pos_y, clip_bottom, clip_top);
          last_next      = steps_left == '0;
          active_next    = 1'b1;
          state_next     = dda_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dda_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and clip registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dda_pkg::ST_IDLE;
      out_valid   <= 1'b0;
      line_active <= 1'b0;
      pos_x       <= '0;
      pos_y       <= '0;
      step_x      <= '0;
      step_y      <= '0;
      steps_left  <= '0;
      clip_left   <= dda_pkg::coord_t'(40);
      clip_bottom <= dda_pkg::coord_t'(40);
      clip_right  <= dda_pkg::coord_t'(200);
      clip_top    <= dda_pkg::coord_t'(200);
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      line_active <= line_active_next;
      pos_x       <= pos_x_next;
      pos_y       <= pos_y_next;
      step_x      <= step_x_next;
      step_y      <= step_y_next;
      steps_left  <= steps_left_next;
      if (cfg_write) begin
        unique case (dda_pkg::reg_idx_t'(cfg_index))
          dda_pkg::REG_CLIP_LEFT:   clip_left   <= cfg_data;
          dda_pkg::REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
          dda_pkg::REG_CLIP_RIGHT:  clip_right  <= cfg_data;
          dda_pkg::REG_CLIP_TOP:    clip_top    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Divider and output payload registers.
  always_ff @(posedge clk) begin
    len     <= len_next;
    mag_y   <= mag_y_next;
    neg_x   <= neg_x_next;
    neg_y   <= neg_y_next;
    rem     <= rem_next;
    quo     <= quo_next;
    dcnt    <= dcnt_next;
    axis    <= axis_next;
    pixel_x <= pixel_x_next;
    pixel_y <= pixel_y_next;
    visible <= visible_next;
    last    <= last_next;
    active  <= active_next;
  end

endmodule
